// ===== hw/rtl/etuc_pkg.sv =====
package etuc_pkg;

  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [5:0]  SecsPerMin  = 6'd60;

  localparam logic [19:0] DaysTo0300  = 20'd719468;
  localparam logic [19:0] Era4Start   = 20'd584388;
  localparam logic [19:0] Era5Start   = 20'd730485;
  localparam logic [17:0] EraLastDay  = 18'd146096;
  localparam logic [17:0] CentDays1   = 18'd36524;
  localparam logic [17:0] CentDays2   = 18'd73048;
  localparam logic [17:0] CentDays3   = 18'd109572;
  localparam logic [11:0] Era4Year    = 12'd1600;
  localparam logic [11:0] Era5Year    = 12'd2000;

  // Reciprocals rounded up; each shift is wide enough that the quotient is exact
  // over the whole operand range that reaches it.
  localparam int unsigned DayShift  = 35;
  localparam int unsigned D1460Shift = 29;
  localparam int unsigned D365Shift  = 27;
  localparam int unsigned D153Shift  = 19;
  localparam int unsigned D5Shift    = 14;
  localparam int unsigned HourShift  = 29;
  localparam int unsigned MinShift   = 18;

  localparam logic [25:0] RecipDay  = 26'(((64'd1 << DayShift) + 64'd674) / 64'd675);
  localparam logic [18:0] Recip1460 = 19'(((64'd1 << D1460Shift) + 64'd1459) / 64'd1460);
  localparam logic [18:0] Recip365  = 19'(((64'd1 << D365Shift) + 64'd364) / 64'd365);
  localparam logic [11:0] Recip153  = 12'(((64'd1 << D153Shift) + 64'd152) / 64'd153);
  localparam logic [11:0] Recip5    = 12'(((64'd1 << D5Shift) + 64'd4) / 64'd5);
  localparam logic [17:0] RecipHour = 18'(((64'd1 << HourShift) + 64'd3599) / 64'd3600);
  localparam logic [12:0] RecipMin  = 13'(((64'd1 << MinShift) + 64'd59) / 64'd60);

  localparam int unsigned SplitLat = 2;
  localparam int unsigned ConvLat  = 6;
  localparam int unsigned TotalLat = SplitLat + ConvLat + 1;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

endpackage

// ===== hw/rtl/etuc_split.sv =====
module etuc_split
  import etuc_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] secs_i,
  output logic [15:0] days_o,
  output logic [16:0] sod_o
);

  logic [50:0] day_prod;
  logic [33:0] back_prod;
  logic [15:0] days_q, days_d, days2_q;
  logic [16:0] lo_q, sod_d, sod_q;

  assign day_prod = 51'(secs_i[31:7]) * 51'(RecipDay);
  assign days_d   = day_prod[50:35];

  assign back_prod = 34'(days_q) * 34'(SecsPerDay);
  assign sod_d     = lo_q - back_prod[16:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      days_q  <= days_d;
      lo_q    <= secs_i[16:0];
      days2_q <= days_q;
      sod_q   <= sod_d;
    end
  end

  assign days_o = days2_q;
  assign sod_o  = sod_q;

endmodule

// ===== hw/rtl/etuc_civil.sv =====
module etuc_civil
  import etuc_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] days_i,
  output date_t       date_o
);

  logic [19:0] z;
  logic        era5_d;
  logic [17:0] doe_d;
  logic [17:0] doe1_q, doe2_q, doe3_q;
  logic        era1_q, era2_q, era3_q, era4_q, era5_q;

  logic [36:0] p1460;
  logic [7:0]  q1460;
  logic [2:0]  ncent;
  logic [17:0] numer_d, numer_q;

  logic [36:0] p365;
  logic [8:0]  yoe_d, yoe3_q, yoe4_q, yoe5_q;

  logic [1:0]  y100;
  logic [17:0] ybase;
  logic [8:0]  doy_d, doy4_q, doy5_q;

  logic [10:0] mp_num;
  logic [22:0] pmp;
  logic [3:0]  mp_d, mp_q;

  logic [10:0] t153;
  logic [22:0] p5;
  logic [8:0]  q5;
  date_t       date_d, date_q;

  assign z      = 20'(days_i) + DaysTo0300;
  assign era5_d = (z >= Era5Start);
  assign doe_d  = 18'(z - (era5_d ? Era5Start : Era4Start));

  assign p1460   = 37'(doe1_q) * 37'(Recip1460);
  assign q1460   = p1460[36:29];
  assign ncent   = 3'(doe1_q >= CentDays1) + 3'(doe1_q >= CentDays2) +
                   3'(doe1_q >= CentDays3) + 3'(doe1_q >= EraLastDay);
  assign numer_d = doe1_q - 18'(q1460) + 18'(ncent) - 18'(doe1_q == EraLastDay);

  assign p365  = 37'(numer_q) * 37'(Recip365);
  assign yoe_d = p365[35:27];

  assign y100  = 2'(yoe3_q >= 9'd100) + 2'(yoe3_q >= 9'd200) + 2'(yoe3_q >= 9'd300);
  assign ybase = 18'(18'(yoe3_q) * 18'd365) + 18'(yoe3_q[8:2]) - 18'(y100);
  assign doy_d = 9'(doe3_q - ybase);

  assign mp_num = 11'(11'(doy4_q) * 11'd5) + 11'd2;
  assign pmp    = 23'(mp_num) * 23'(Recip153);
  assign mp_d   = pmp[22:19];

  assign t153 = 11'(11'(mp_q) * 11'd153) + 11'd2;
  assign p5   = 23'(t153) * 23'(Recip5);
  assign q5   = p5[22:14];

  always_comb begin
    date_d.day   = 5'(doy5_q - q5 + 9'd1);
    date_d.month = (mp_q < 4'd10) ? mp_q + 4'd3 : mp_q - 4'd9;
    date_d.year  = 12'(yoe5_q) + (era5_q ? Era5Year : Era4Year) +
                   12'(date_d.month <= 4'd2);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      doe1_q  <= doe_d;
      era1_q  <= era5_d;
      numer_q <= numer_d;
      doe2_q  <= doe1_q;
      era2_q  <= era1_q;
      yoe3_q  <= yoe_d;
      doe3_q  <= doe2_q;
      era3_q  <= era2_q;
      doy4_q  <= doy_d;
      yoe4_q  <= yoe3_q;
      era4_q  <= era3_q;
      mp_q    <= mp_d;
      doy5_q  <= doy4_q;
      yoe5_q  <= yoe4_q;
      era5_q  <= era4_q;
      date_q  <= date_d;
    end
  end

  assign date_o = date_q;

endmodule

// ===== hw/rtl/etuc_tod.sv =====
module etuc_tod
  import etuc_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [16:0] sod_i,
  output tod_t        tod_o
);

  logic [34:0] phour;
  logic [4:0]  hh_d, hh1_q, hh2_q, hh3_q;
  logic [16:0] sod1_q;
  logic [11:0] rem_d, rem2_q, rem3_q;
  logic [24:0] pmin;
  logic [5:0]  mi_d, mi3_q;
  tod_t        tod_d, tod4_q, tod5_q, tod6_q;

  assign phour = 35'(sod_i) * 35'(RecipHour);
  assign hh_d  = phour[33:29];

  assign rem_d = 12'(sod1_q - 17'(17'(hh1_q) * 17'(SecsPerHour)));

  assign pmin = 25'(rem2_q) * 25'(RecipMin);
  assign mi_d = pmin[23:18];

  always_comb begin
    tod_d.hour   = hh3_q;
    tod_d.minute = mi3_q;
    tod_d.second = 6'(rem3_q - 12'(12'(mi3_q) * 12'(SecsPerMin)));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh1_q  <= hh_d;
      sod1_q <= sod_i;
      rem2_q <= rem_d;
      hh2_q  <= hh1_q;
      mi3_q  <= mi_d;
      rem3_q <= rem2_q;
      hh3_q  <= hh2_q;
      tod4_q <= tod_d;
      tod5_q <= tod4_q;
      tod6_q <= tod5_q;
    end
  end

  assign tod_o = tod6_q;

endmodule

// ===== hw/rtl/epoch_to_utc_calendar_unit.sv =====
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into a
// civil date and time of day, together with a status bit for an unset clock.
// The input channel carries epoch_seconds_i and clock_known_i under
// in_valid_i/in_stall_o; the result channel carries status_o and the date and
// time fields under out_valid_o/out_stall_i. A transfer happens on a clock
// edge where valid is high and stall is low.
// The pipeline has nine register stages, and one transfer per cycle is sustained
// while the receiver does not stall.
// The depth is set by the day split and the chain of constant-reciprocal
// multiplies in the date conversion, each followed by a register.
// When the clock is not known, status_o is 1 and all other fields are zero.
// Reset clears every valid bit, so no result is presented after reset.
// While the receiver stalls a presented result, the whole pipeline holds and
// in_stall_o is raised; nothing is dropped or repeated.
module epoch_to_utc_calendar_unit
  import etuc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] epoch_seconds_i,
  input  logic        clock_known_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);

  logic                 en;
  logic [TotalLat-1:0]  vld_q;
  logic [TotalLat-2:0]  knw_q;
  logic [15:0]          days;
  logic [16:0]          sod;
  date_t                date;
  tod_t                 tod;
  logic                 known;
  logic                 status_q;
  date_t                date_q;
  tod_t                 tod_q;

  assign en         = !(vld_q[TotalLat-1] && out_stall_i);
  assign in_stall_o = !en;

  etuc_split u_split (
    .clk_i  (clk_i),
    .en_i   (en),
    .secs_i (epoch_seconds_i),
    .days_o (days),
    .sod_o  (sod)
  );

  etuc_civil u_civil (
    .clk_i  (clk_i),
    .en_i   (en),
    .days_i (days),
    .date_o (date)
  );

  etuc_tod u_tod (
    .clk_i (clk_i),
    .en_i  (en),
    .sod_i (sod),
    .tod_o (tod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TotalLat-2:0], in_valid_i};
    end
  end

  assign known = knw_q[TotalLat-2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      knw_q    <= {knw_q[TotalLat-3:0], clock_known_i};
      status_q <= !known;
      date_q   <= known ? date : '0;
      tod_q    <= known ? tod : '0;
    end
  end

  assign out_valid_o = vld_q[TotalLat-1];
  assign status_o    = status_q;
  assign year_o      = date_q.year;
  assign month_o     = date_q.month;
  assign day_o       = date_q.day;
  assign hour_o      = tod_q.hour;
  assign minute_o    = tod_q.minute;
  assign second_o    = tod_q.second;

endmodule

// ===== tb/calendar_checker.sv =====
module calendar_checker
  import etuc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] epoch_seconds_i,
  input  logic        clock_known_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        status_i,
  input  logic [11:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [5:0]  second_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DaySeconds   = 86400;
  localparam int unsigned HourSeconds  = 3600;
  localparam int unsigned MinSeconds   = 60;
  localparam int unsigned MarchZeroDay = 719468;
  localparam int unsigned EraDays      = 146097;

  typedef struct packed {
    logic  status;
    date_t date;
    tod_t  tod;
  } civil_t;

  civil_t awaited_civil_q[$];

  function automatic civil_t civil_from_epoch(logic [31:0] secs, logic known);
    civil_t      res;
    logic [31:0] sod;
    logic [31:0] z;
    logic [31:0] era;
    logic [31:0] doe;
    logic [31:0] yoe;
    logic [31:0] doy;
    logic [31:0] mp;
    logic [31:0] mon;
    logic [31:0] yr;
    res = '0;
    if (!known) begin
      res.status = 1'b1;
      return res;
    end
    sod = secs % DaySeconds;
    // The calendar year is counted from March 1, so the leap day ends it.
    z   = secs / DaySeconds + MarchZeroDay;
    era = z / EraDays;
    doe = z - era * EraDays;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    mon = (mp < 10) ? mp + 3 : mp - 9;
    yr  = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
    res.date.year   = yr[11:0];
    res.date.month  = mon[3:0];
    res.date.day    = 5'(doy - (153 * mp + 2) / 5 + 1);
    res.tod.hour    = 5'(sod / HourSeconds);
    res.tod.minute  = 6'((sod / MinSeconds) % 60);
    res.tod.second  = 6'(sod % MinSeconds);
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches_o++;
    end
  endtask

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i) begin : watch
    civil_t seen;
    civil_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        awaited_civil_q.push_back(civil_from_epoch(epoch_seconds_i, clock_known_i));
      end
      if (out_valid_i && !out_stall_i) begin
        seen = {status_i, year_i, month_i, day_i, hour_i, minute_i, second_i};
        if (awaited_civil_q.size() == 0) begin
          $error("Result transfer arrived with no conversion outstanding.");
          mismatches_o++;
        end else begin
          want = awaited_civil_q.pop_front();
          check_field("status", want.status, seen.status);
          check_field("year", want.date.year, seen.date.year);
          check_field("month", want.date.month, seen.date.month);
          check_field("day", want.date.day, seen.date.day);
          check_field("hour", want.tod.hour, seen.tod.hour);
          check_field("minute", want.tod.minute, seen.tod.minute);
          check_field("second", want.tod.second, seen.tod.second);
        end
      end
    end
    pending_o = awaited_civil_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
module testbench
  import etuc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned PhaseItems    = 235;
  localparam int unsigned LastFullDay   = 49709;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] epoch_seconds;
  logic        clock_known;
  logic        out_valid;
  logic        out_stall;
  logic        status;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_left;
  bit          hold_request;
  int unsigned stamps_sent;
  int unsigned unknown_sent;

  epoch_to_utc_calendar_unit i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .epoch_seconds_i(epoch_seconds),
    .clock_known_i  (clock_known),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .year_o         (year),
    .month_o        (month),
    .day_o          (day),
    .hour_o         (hour),
    .minute_o       (minute),
    .second_o       (second)
  );

  calendar_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .epoch_seconds_i(epoch_seconds),
    .clock_known_i  (clock_known),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .year_i         (year),
    .month_i        (month),
    .day_i          (day),
    .hour_i         (hour),
    .minute_i       (minute),
    .second_i       (second),
    .mismatches_o   (mismatches),
    .pending_o      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // The receiver counts a long hold-off on its own; otherwise it stalls at random.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_stamp(input logic [31:0] secs, input logic known);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    epoch_seconds <= secs;
    clock_known   <= known;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    stamps_sent++;
    if (!known) unknown_sent++;
    @(negedge clk);
  endtask

  task automatic enter_phase(input int unsigned idle, input int unsigned stall, input bit hold);
    @(posedge clk);
    send_idle_pct = idle;
    stall_pct     = stall;
    hold_request  = hold;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] random_epoch();
    logic [31:0] secs;
    case ($urandom_range(9))
      0, 1, 2, 3: secs = $urandom();
      4, 5, 6: begin
        secs = $urandom_range(LastFullDay) * 86400;
        case ($urandom_range(2))
          0:       secs = secs + 86399;
          1:       secs = secs + $urandom_range(86399);
          default: secs = secs;
        endcase
      end
      7, 8:    secs = $urandom_range(200000);
      default: secs = 32'hFFFF_FFFF - $urandom_range(200000);
    endcase
    return secs;
  endfunction

  initial begin
    int unsigned phase_idle[4];
    int unsigned phase_stall[4];
    phase_idle  = '{0, 48, 0, 35};
    phase_stall = '{0, 0, 48, 35};
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    epoch_seconds = '0;
    clock_known   = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 1'b0;
    stamps_sent   = 0;
    unknown_sent  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_stamp(32'd0, 1'b1);
    send_stamp(32'hFFFF_FFFF, 1'b1);
    send_stamp(32'hFFFF_FFFF, 1'b0);
    send_stamp(32'd0, 1'b0);
    send_stamp($urandom(), 1'b0);
    send_stamp(32'd86399, 1'b1);
    send_stamp(32'd86400, 1'b1);
    send_stamp(32'd31535999, 1'b1);
    send_stamp(32'd68169600, 1'b1);
    send_stamp(32'd946684799, 1'b1);
    send_stamp(32'd951782400, 1'b1);
    send_stamp(32'd951868800, 1'b1);
    send_stamp(32'd2147483647, 1'b1);
    send_stamp(32'd2147483648, 1'b1);
    send_stamp(32'd4107542399, 1'b1);
    send_stamp(32'd4107542400, 1'b1);
    send_stamp(32'h5555_5555, 1'b1);
    send_stamp(32'hAAAA_AAAA, 1'b1);
    drain_results();

    for (int p = 0; p < 4; p++) begin
      enter_phase(phase_idle[p], phase_stall[p], p == 0);
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 3 && n == PhaseItems / 2) drain_results();
        send_stamp(random_epoch(), $urandom_range(9) != 0);
      end
      drain_results();
    end

    repeat (TotalLat + 8) @(negedge clk);
    $display("Converted %0d timestamps, %0d of them with the clock unknown,", stamps_sent,
             unknown_sent);
    $display("across idle, stall and long hold-off phases in %0d cycles.", cycle_count);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
